/* rtl/core/pl_pkg.sv */
package pl_pkg;

	localparam int FUNC_W = 2;
	localparam int POS_W  = 8;
	localparam int DATA_W = 32;
	localparam int LEN_W  = 5;
	// compare width for position against length + 1
	localparam int CMP_W  = POS_W + 1;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_READ   = 2'd2,
		FN_RSVD   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SH_RD,
		S_SH_WR,
		S_PUT,
		S_RD_OUT
	} state_t;

	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [DATA_W-1:0] rd;
		logic [LEN_W-1:0]  len;
	} fin_t;

endpackage

/* rtl/core/pl_store.sv */
module pl_store #(
	parameter int DEPTH  = 16,
	parameter int WORD_W = 32,
	parameter int AW     = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read word holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/pl_seq.sv */
module pl_seq #(
	parameter int CAPACITY  = 16,
	parameter int WORD_BITS = 32,
	parameter int AW        = 4,
	parameter int CW        = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [pl_pkg::FUNC_W-1:0]   func,
	input  logic [pl_pkg::POS_W-1:0]    position,
	input  logic [pl_pkg::DATA_W-1:0]   value,
	output logic                        we,
	output logic [AW-1:0]               waddr,
	output logic [WORD_BITS-1:0]        wdata,
	output logic                        re,
	output logic [AW-1:0]               raddr,
	input  logic [WORD_BITS-1:0]        rdata,
	output pl_pkg::fin_t                fin
);

	localparam int CMP_W = pl_pkg::CMP_W;

	pl_pkg::state_t state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [AW-1:0]  idx_q, idx_d;
	pl_pkg::func_t  func_q;
	logic [pl_pkg::POS_W-1:0]  pos_q;
	logic [pl_pkg::DATA_W-1:0] value_q;

	logic [pl_pkg::POS_W-1:0] pm1;
	logic [AW-1:0]            pm1_a;
	logic [AW-1:0]            idx_step;
	logic [CMP_W-1:0]         pos_w, cnt_w;
	pl_pkg::status_t          chk_st;
	logic [63:0]              val64;
	logic signed [WORD_BITS-1:0] rd_s;
	logic signed [63:0]       rd64;

	assign pm1      = pos_q - pl_pkg::POS_W'(1);
	assign pm1_a    = AW'(pm1);
	assign pos_w    = CMP_W'(pos_q);
	assign cnt_w    = CMP_W'(count_q);
	// shared index unit: down for insert, up for delete
	assign idx_step = (func_q == pl_pkg::FN_INSERT) ? idx_q - AW'(1) : idx_q + AW'(1);
	assign val64    = {32'd0, value_q};
	assign rd_s     = rdata;
	assign rd64     = 64'(rd_s);
	assign busy     = (state_q != pl_pkg::S_IDLE);

	always_comb begin
		chk_st = pl_pkg::ST_OK;
		unique case (func_q)
			pl_pkg::FN_INSERT: begin
				if (count_q == '0 && pos_q != pl_pkg::POS_W'(1)) begin
					chk_st = pl_pkg::ST_EMPTY;
				end else if (pos_q == '0 || pos_w > cnt_w + CMP_W'(1)) begin
					chk_st = pl_pkg::ST_BADPOS;
				end else if (cnt_w >= CMP_W'(CAPACITY)) begin
					chk_st = pl_pkg::ST_FULL;
				end
			end
			pl_pkg::FN_DELETE, pl_pkg::FN_READ: begin
				if (count_q == '0) begin
					chk_st = pl_pkg::ST_EMPTY;
				end else if (pos_q == '0 || pos_w > cnt_w) begin
					chk_st = pl_pkg::ST_BADPOS;
				end
			end
			default: chk_st = pl_pkg::ST_BADPOS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pl_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (start && !busy) begin
			func_q  <= pl_pkg::func_t'(func);
			pos_q   <= position;
			value_q <= value;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		idx_d      = idx_q;
		we         = 1'b0;
		waddr      = idx_q;
		wdata      = rdata;
		re         = 1'b0;
		raddr      = idx_step;
		fin.valid  = 1'b0;
		fin.status = pl_pkg::ST_OK;
		fin.rd     = '0;
		fin.len    = '0;
		unique case (state_q)
			pl_pkg::S_IDLE: begin
				if (start) begin
					state_d = pl_pkg::S_CHECK;
				end
			end
			pl_pkg::S_CHECK: begin
				if (chk_st != pl_pkg::ST_OK) begin
					fin.valid  = 1'b1;
					fin.status = chk_st;
					state_d    = pl_pkg::S_IDLE;
				end else begin
					unique case (func_q)
						pl_pkg::FN_INSERT: begin
							idx_d   = AW'(count_q);
							state_d = (cnt_w == CMP_W'(pm1)) ? pl_pkg::S_PUT
							                                 : pl_pkg::S_SH_RD;
						end
						pl_pkg::FN_DELETE: begin
							idx_d = pm1_a;
							if (pos_w == cnt_w) begin
								count_d    = count_q - CW'(1);
								fin.valid  = 1'b1;
								state_d    = pl_pkg::S_IDLE;
							end else begin
								state_d = pl_pkg::S_SH_RD;
							end
						end
						default: begin
							re      = 1'b1;
							raddr   = pm1_a;
							state_d = pl_pkg::S_RD_OUT;
						end
					endcase
				end
			end
			pl_pkg::S_SH_RD: begin
				re      = 1'b1;
				state_d = pl_pkg::S_SH_WR;
			end
			pl_pkg::S_SH_WR: begin
				we    = 1'b1;
				idx_d = idx_step;
				if (func_q == pl_pkg::FN_INSERT) begin
					state_d = (idx_step == pm1_a) ? pl_pkg::S_PUT : pl_pkg::S_SH_RD;
				end else if (CMP_W'(idx_step) + CMP_W'(1) == cnt_w) begin
					count_d   = count_q - CW'(1);
					fin.valid = 1'b1;
					state_d   = pl_pkg::S_IDLE;
				end else begin
					state_d = pl_pkg::S_SH_RD;
				end
			end
			pl_pkg::S_PUT: begin
				we        = 1'b1;
				waddr     = pm1_a;
				wdata     = val64[WORD_BITS-1:0];
				count_d   = count_q + CW'(1);
				fin.valid = 1'b1;
				state_d   = pl_pkg::S_IDLE;
			end
			pl_pkg::S_RD_OUT: begin
				fin.valid = 1'b1;
				fin.rd    = rd64[pl_pkg::DATA_W-1:0];
				state_d   = pl_pkg::S_IDLE;
			end
			default: state_d = pl_pkg::S_IDLE;
		endcase
		fin.len = pl_pkg::LEN_W'(count_d);
	end

endmodule

/* rtl/core/positional_list_engine_top.sv */
// Ordered list of up to CAPACITY signed words. A command word is taken when
// start is high and busy is low; busy stays high until the command is done.
// Each command gives exactly one result, shown on read_value, status and
// length_after for the single cycle in which done is high; the receiver
// cannot stall, so it must take the result in that cycle. The store has one
// read and one write port; each word moved is read in S_SH_RD and written
// in S_SH_WR. A rejected command ends in S_CHECK; a read goes on to
// S_RD_OUT, an insert shifts words up and writes in S_PUT, a delete shifts
// any later words down. done rises in the same cycle in which busy falls,
// and a new command may be started in that cycle.
module positional_list_engine_top #(
	parameter int CAPACITY  = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [pl_pkg::FUNC_W-1:0]         func,
	input  logic [pl_pkg::POS_W-1:0]          position,
	input  logic signed [pl_pkg::DATA_W-1:0]  value,
	output logic                              done,
	output logic signed [pl_pkg::DATA_W-1:0]  read_value,
	output logic [1:0]                        status,
	output logic [pl_pkg::LEN_W-1:0]          length_after
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                 we, re;
	logic [AW-1:0]        waddr, raddr;
	logic [WORD_BITS-1:0] wdata, rdata;
	pl_pkg::fin_t         fin;

	logic                      done_q;
	logic [pl_pkg::DATA_W-1:0] rd_q;
	pl_pkg::status_t           status_q;
	logic [pl_pkg::LEN_W-1:0]  len_q;

	pl_store #(
		.DEPTH  (CAPACITY),
		.WORD_W (WORD_BITS),
		.AW     (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	pl_seq #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.position (position),
		.value    (value),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.re       (re),
		.raddr    (raddr),
		.rdata    (rdata),
		.fin      (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	// result word registers
	always_ff @(posedge clk) begin
		if (fin.valid) begin
			rd_q     <= fin.rd;
			status_q <= fin.status;
			len_q    <= fin.len;
		end
	end

	assign done         = done_q;
	assign read_value   = rd_q;
	assign status       = status_q;
	assign length_after = len_q;

endmodule
